[sv/erpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package erpp_pkg;

  localparam int COORD_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 15;

  // Derived widths along the datapath
  localparam int TW   = TRIG_FRAC_BITS + 2;      // signed sine / cosine
  localparam int CW   = COORD_BITS;              // signed coordinate
  localparam int P1W  = TW + CW;                 // trig times coordinate
  localparam int Y1W  = P1W + 1;                 // after first rotation
  localparam int X2W  = TW + Y1W + 1;            // after second rotation
  localparam int XHW  = X2W - TRIG_FRAC_BITS;    // high part of x2
  localparam int AW   = TW + XHW + 1;            // high partial sum
  localparam int BW   = TW + TRIG_FRAC_BITS + 1; // low partial product
  localparam int TOPW = AW + 2;                  // sum with center offset
  localparam int QW   = TOPW - 2 * TRIG_FRAC_BITS;
  localparam int ANG_W = 9;
  localparam int CTR_W = 11;
  localparam int OUT_W = 14;

  localparam logic signed [QW-1:0] OUT_MAX = QW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [QW-1:0] OUT_MIN = -QW'(1 << (OUT_W - 1));

  // Move the 15-bit-fraction table entries to TRIG_FRAC_BITS
  localparam int TRIG_DN  = (TRIG_FRAC_BITS < 15) ? 15 - TRIG_FRAC_BITS : 0;
  localparam int TRIG_UP  = (TRIG_FRAC_BITS > 15) ? TRIG_FRAC_BITS - 15 : 0;
  localparam int TRIG_RND = (1 << TRIG_DN) >> 1;

  typedef enum logic [1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2,
    REG_CENTER  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TW-1:0] s1;
    logic signed [TW-1:0] c1;
    logic signed [TW-1:0] s2;
    logic signed [TW-1:0] c2;
    logic signed [TW-1:0] s3;
    logic signed [TW-1:0] c3;
  } trig_t;

  typedef struct packed {
    logic signed [AW-1:0] ax;
    logic signed [BW-1:0] bx;
    logic signed [AW-1:0] ay;
    logic signed [BW-1:0] by;
  } part_t;

  // round(sin(d) * 2^15) for d = 0..90
  function automatic logic [15:0] quarter_sine(input logic [6:0] d);
    logic [15:0] v;
    case (d)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
      7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
      7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
      7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [TW-1:0] trig_mag(input logic [6:0] d);
    logic [31:0] t;
    t = (32'(quarter_sine(d)) + 32'(TRIG_RND)) >> TRIG_DN;
    t = t << TRIG_UP;
    return t[TW-1:0];
  endfunction

  // d must be 0..359
  function automatic logic signed [TW-1:0] sin_deg(input logic [ANG_W-1:0] d);
    logic [ANG_W-1:0] f;
    logic             neg;
    logic [TW-1:0]    mag;
    if (d <= ANG_W'(90)) begin
      f = d;
      neg = 1'b0;
    end else if (d <= ANG_W'(180)) begin
      f = ANG_W'(180) - d;
      neg = 1'b0;
    end else if (d <= ANG_W'(270)) begin
      f = d - ANG_W'(180);
      neg = 1'b1;
    end else begin
      f = ANG_W'(360) - d;
      neg = 1'b1;
    end
    mag = trig_mag(f[6:0]);
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic [ANG_W-1:0] wrap360(input logic [ANG_W:0] a);
    logic [ANG_W:0] w;
    w = (a >= (ANG_W + 1)'(360)) ? a - (ANG_W + 1)'(360) : a;
    return w[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/erpp_trig.sv]
`timescale 1ns / 1ps
`default_nettype none

module erpp_trig (
  input  wire logic                       clk_i,
  input  wire logic [erpp_pkg::ANG_W-1:0] angle_x_i,
  input  wire logic [erpp_pkg::ANG_W-1:0] angle_y_i,
  input  wire logic [erpp_pkg::ANG_W-1:0] angle_z_i,
  output erpp_pkg::trig_t                 trig_o
);
  import erpp_pkg::*;

  logic [ANG_W-1:0] dx, dy, dz;
  trig_t            trig_d, trig_q;

  always_comb begin
    dx = wrap360({1'b0, angle_x_i});
    dy = wrap360({1'b0, angle_y_i});
    dz = wrap360({1'b0, angle_z_i});
    trig_d.s1 = sin_deg(dx);
    trig_d.c1 = sin_deg(wrap360({1'b0, dx} + (ANG_W + 1)'(90)));
    trig_d.s2 = sin_deg(dy);
    trig_d.c2 = sin_deg(wrap360({1'b0, dy} + (ANG_W + 1)'(90)));
    trig_d.s3 = sin_deg(dz);
    trig_d.c3 = sin_deg(wrap360({1'b0, dz} + (ANG_W + 1)'(90)));
  end

  // Refresh every cycle; the user must change the angles only while the pipeline is empty, as nothing here enforces it
  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

[sv/erpp_rotate.sv]
`timescale 1ns / 1ps
`default_nettype none

module erpp_rotate (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic signed [erpp_pkg::CW-1:0]  x_i,
  input  wire logic signed [erpp_pkg::CW-1:0]  y_i,
  input  wire logic signed [erpp_pkg::CW-1:0]  z_i,
  input  wire erpp_pkg::trig_t                 trig_i,
  output logic                                 valid_o,
  output erpp_pkg::part_t                      part_o
);
  import erpp_pkg::*;

  // Stage B: rotate about X
  logic                  vb_q;
  logic signed [CW-1:0]  xb_q;
  logic signed [Y1W-1:0] y1_d, y1_q, z1_d, z1_q;
  // Stage C: rotate about Y
  logic                  vc_q;
  logic signed [X2W-1:0] x2_d, x2_q;
  logic signed [Y1W-1:0] yc_q;
  // Stage D: rotate about Z, split into high and low partial sums
  logic                  vd_q;
  part_t                 part_d, part_q;

  logic signed [P1W-1:0]      p_c1y, p_s1z, p_c1z, p_s1y, p_c2x;
  logic signed [TW+Y1W-1:0]   p_s2z, p_s3y, p_c3y;
  logic signed [TW+XHW-1:0]   p_c3xh, p_s3xh;
  logic signed [XHW-1:0]      xh;
  logic signed [TRIG_FRAC_BITS:0] xl;

  always_comb begin
    p_c1y = P1W'(trig_i.c1) * P1W'(y_i);
    p_s1z = P1W'(trig_i.s1) * P1W'(z_i);
    p_c1z = P1W'(trig_i.c1) * P1W'(z_i);
    p_s1y = P1W'(trig_i.s1) * P1W'(y_i);
    y1_d  = Y1W'(p_c1y) + Y1W'(p_s1z);
    z1_d  = Y1W'(p_c1z) - Y1W'(p_s1y);
  end

  always_comb begin
    p_c2x = P1W'(trig_i.c2) * P1W'(xb_q);
    p_s2z = (TW + Y1W)'(trig_i.s2) * (TW + Y1W)'(z1_q);
    x2_d  = (X2W'(p_c2x) <<< TRIG_FRAC_BITS) + X2W'(p_s2z);
  end

  // y2 is y1 scaled by 2^F, so its low part is zero
  always_comb begin
    xh     = signed'(x2_q[X2W-1:TRIG_FRAC_BITS]);
    xl     = signed'({1'b0, x2_q[TRIG_FRAC_BITS-1:0]});
    p_c3xh = (TW + XHW)'(trig_i.c3) * (TW + XHW)'(xh);
    p_s3xh = (TW + XHW)'(trig_i.s3) * (TW + XHW)'(xh);
    p_s3y  = (TW + Y1W)'(trig_i.s3) * (TW + Y1W)'(yc_q);
    p_c3y  = (TW + Y1W)'(trig_i.c3) * (TW + Y1W)'(yc_q);
    part_d.ax = AW'(p_c3xh) - AW'(p_s3y);
    part_d.ay = AW'(p_s3xh) + AW'(p_c3y);
    part_d.bx = BW'(trig_i.c3) * BW'(xl);
    part_d.by = BW'(trig_i.s3) * BW'(xl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      vb_q <= valid_i;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xb_q   <= x_i;
    y1_q   <= y1_d;
    z1_q   <= z1_d;
    x2_q   <= x2_d;
    yc_q   <= y1_q;
    part_q <= part_d;
  end

  assign valid_o = vd_q;
  assign part_o  = part_q;

endmodule

`default_nettype wire

[sv/erpp_finish.sv]
`timescale 1ns / 1ps
`default_nettype none

module erpp_finish (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic signed [erpp_pkg::AW-1:0]   a_i,
  input  wire logic signed [erpp_pkg::BW-1:0]   b_i,
  input  wire logic [erpp_pkg::CTR_W-1:0]       center_i,
  output logic                                  valid_o,
  output logic signed [erpp_pkg::OUT_W-1:0]     result_o
);
  import erpp_pkg::*;

  localparam int F2 = 2 * TRIG_FRAC_BITS;

  // Stage E: fold the low part and the center into one sum
  logic                   ve_q;
  logic signed [TOPW-1:0] top_d, top_q;
  logic                   rem_zero_d, rem_zero_q;
  // Stage F: truncate toward zero and saturate
  logic                   vf_q;
  logic signed [TOPW-1:0] q_full;
  logic signed [QW-1:0]   q;
  logic                   exact;
  logic signed [OUT_W-1:0] res_d, res_q;

  always_comb begin
    top_d = TOPW'(a_i) + TOPW'(b_i >>> TRIG_FRAC_BITS)
          + (signed'(TOPW'(center_i)) <<< F2);
    rem_zero_d = (b_i[TRIG_FRAC_BITS-1:0] == '0);
  end

  always_comb begin
    q_full = top_q >>> F2;
    q      = q_full[QW-1:0];
    exact  = rem_zero_q && (top_q[F2-1:0] == '0);
    // floor to trunc: bump a negative inexact quotient up by one
    if (top_q[TOPW-1] && !exact) begin
      q = q + QW'(1);
    end
    if (q > OUT_MAX) begin
      res_d = OUT_MAX[OUT_W-1:0];
    end else if (q < OUT_MIN) begin
      res_d = OUT_MIN[OUT_W-1:0];
    end else begin
      res_d = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      ve_q <= valid_i;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    rem_zero_q <= rem_zero_d;
    res_q      <= res_d;
  end

  assign valid_o  = vf_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[sv/euler_rotate_project_point.sv]
// Rotates a 3D point about X, then Y, then Z by whole-degree angles and
// projects it onto the screen plane: screen_x/screen_y are the center
// offset plus the rotated x/y, truncated toward zero and saturated to
// 14 bits. A point is taken on every clock with start high (busy is
// always low) and its result appears on done_o at the end of the
// pipeline, for one cycle; results cannot be held off, so
// capture them when done_o is high. One point per clock sustained: the
// work is a six-stage pipeline (input register, one stage per rotation,
// two for offset, rounding and saturation). The sine/cosine table is
// read from the angle registers into a trig register in the cycle after
// configuration write; write configuration only while no point is in
// flight. cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module euler_rotate_project_point (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [erpp_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [erpp_pkg::COORD_BITS-1:0] point_y_i,
  input  wire logic signed [erpp_pkg::COORD_BITS-1:0] point_z_i,
  output logic                                       done_o,
  output logic signed [erpp_pkg::OUT_W-1:0]          screen_x_o,
  output logic signed [erpp_pkg::OUT_W-1:0]          screen_y_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [1:0]                            cfg_index_i,
  input  wire logic [erpp_pkg::CTR_W-1:0]            cfg_data_i
);
  import erpp_pkg::*;

  logic [ANG_W-1:0] angle_x_q, angle_y_q, angle_z_q;
  logic [CTR_W-1:0] center_q;

  logic             va_q;
  logic signed [CW-1:0] xa_q, ya_q, za_q;

  trig_t            trig;
  logic             rot_valid;
  part_t            part;
  logic             done_x, done_y;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      center_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ANGLE_X: angle_x_q <= cfg_data_i[ANG_W-1:0];
        REG_ANGLE_Y: angle_y_q <= cfg_data_i[ANG_W-1:0];
        REG_ANGLE_Z: angle_z_q <= cfg_data_i[ANG_W-1:0];
        REG_CENTER:  center_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q <= point_x_i;
    ya_q <= point_y_i;
    za_q <= point_z_i;
  end

  erpp_trig u_trig (
    .clk_i     (clk_i),
    .angle_x_i (angle_x_q),
    .angle_y_i (angle_y_q),
    .angle_z_i (angle_z_q),
    .trig_o    (trig)
  );

  erpp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .x_i     (xa_q),
    .y_i     (ya_q),
    .z_i     (za_q),
    .trig_i  (trig),
    .valid_o (rot_valid),
    .part_o  (part)
  );

  erpp_finish u_finish_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rot_valid),
    .a_i      (part.ax),
    .b_i      (part.bx),
    .center_i (center_q),
    .valid_o  (done_x),
    .result_o (screen_x_o)
  );

  erpp_finish u_finish_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rot_valid),
    .a_i      (part.ay),
    .b_i      (part.by),
    .center_i (center_q),
    .valid_o  (done_y),
    .result_o (screen_y_o)
  );

  // Both lanes carry the same valid chain
  assign done_o = done_x & done_y;

endmodule

`default_nettype wire
